/* rtl/core/tvg_pkg.sv */
// Shared widths, register codes, reset values and types of the tile scan-out block.
package tvg_pkg;

    localparam int LINE_W     = 10;
    localparam int VIS_W      = 9;
    localparam int COORD_W    = 8;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [COLOR_W-1:0] COLOR_MASK = 8'hCF;
    localparam logic [LINE_W-1:0]  LINE_MAX   = 10'd1023;

    localparam logic [LINE_W-1:0] RST_LAST_LINE     = 10'd524;
    localparam logic [LINE_W-1:0] RST_VSYNC_START   = 10'd490;
    localparam logic [LINE_W-1:0] RST_VSYNC_STOP    = 10'd492;
    localparam logic [VIS_W-1:0]  RST_VISIBLE_LINES = 9'd480;

    localparam logic [CFG_IDX_W-1:0] REG_LAST_LINE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VSYNC_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VSYNC_STOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_LINES = 2'd3;

    typedef struct packed {
        logic [LINE_W-1:0] last_line;
        logic [LINE_W-1:0] vsync_start;
        logic [LINE_W-1:0] vsync_stop;
        logic [VIS_W-1:0]  visible_lines;
    } cfg_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [LINE_W-1:0] row;
        logic              vsync;
        logic              show;
    } tick_info_t;

endpackage

/* rtl/core/tile_vga_scanline_generator.sv */
// Top level of the tile-mapped scan-out block: configuration registers and submodules.
//
// Usage: a request is taken when start is high and busy is low. With mode low the
// request is a line tick: the line counter updates vertical sync, then a visible
// line gives TILE_COLUMNS results on consecutive cycles, the first once the store
// read is registered, with busy high through the last result. A non-visible or
// final line gives one blank result the cycle after the request, busy for one cycle.
// With mode high the request fills a clamped rectangle, one tile per cycle; busy is
// high while the tiles are written, and an empty rectangle writes nothing, busy low.
// The tile store has one write and one read port, walked by a single address counter.
// Results appear for one cycle under result_valid and cannot be held off.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// while the block is idle; the user must keep to this, as the block does not
// enforce it. After reset the block sweeps the store to black, TILE_ROWS times the
// next power of two at or above TILE_COLUMNS entries (3840 at the default size),
// with busy high; configuration writes are still taken during the sweep.
module tile_vga_scanline_generator #(
    parameter int TILE_COLUMNS = 60,
    parameter int TILE_ROWS    = 60,
    parameter int ROW_HEIGHT   = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               mode,
    input  logic [7:0]                         left,
    input  logic [7:0]                         top,
    input  logic [7:0]                         right,
    input  logic [7:0]                         bottom,
    input  logic [7:0]                         fill_color,
    output logic                               result_valid,
    output logic [7:0]                         pixel_color,
    output logic                               visible,
    output logic                               vsync_active,
    output logic [9:0]                         line_index,
    output logic                               last_of_line,
    input  logic                               cfg_write,
    input  logic [tvg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tvg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tvg_pkg::*;

    localparam int COL_W = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
    localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

    cfg_t       cfg_reg, cfg_next;
    tick_info_t info;
    logic       tick;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LAST_LINE:     cfg_next.last_line     = cfg_data;
                REG_VSYNC_START:   cfg_next.vsync_start   = cfg_data;
                REG_VSYNC_STOP:    cfg_next.vsync_stop    = cfg_data;
                REG_VISIBLE_LINES: cfg_next.visible_lines = cfg_data[VIS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.last_line     <= RST_LAST_LINE;
            cfg_reg.vsync_start   <= RST_VSYNC_START;
            cfg_reg.vsync_stop    <= RST_VSYNC_STOP;
            cfg_reg.visible_lines <= RST_VISIBLE_LINES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tvg_line_ctrl #(
        .ROW_HEIGHT (ROW_HEIGHT)
    ) u_line_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .tick  (tick),
        .info  (info)
    );

    tvg_walker #(
        .TILE_COLUMNS (TILE_COLUMNS),
        .TILE_ROWS    (TILE_ROWS),
        .COL_W        (COL_W),
        .ROW_W        (ROW_W)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .left         (left),
        .top          (top),
        .right        (right),
        .bottom       (bottom),
        .fill_color   (fill_color),
        .info         (info),
        .tick         (tick),
        .busy         (busy),
        .result_valid (result_valid),
        .pixel_color  (pixel_color),
        .visible      (visible),
        .vsync_active (vsync_active),
        .line_index   (line_index),
        .last_of_line (last_of_line)
    );

endmodule

/* rtl/core/tvg_tile_mem.sv */
// Tile colour store: one write port and one registered read port.
module tvg_tile_mem #(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 3840
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/tvg_line_ctrl.sv */
// Line counter with tile row tracking and vertical sync state.
module tvg_line_ctrl #(
    parameter int ROW_HEIGHT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tvg_pkg::cfg_t       cfg,
    input  logic                tick,
    output tvg_pkg::tick_info_t info
);
    import tvg_pkg::*;

    localparam int SUB_W = (ROW_HEIGHT > 1) ? $clog2(ROW_HEIGHT) : 1;

    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W-1:0] row_reg, row_next;
    logic [SUB_W-1:0]  sub_reg, sub_next;
    logic              vsync_reg, vsync_next;
    logic              vsync_upd;
    logic              is_last;

    always_comb
    begin
        vsync_upd = vsync_reg;
        if (line_reg == cfg.vsync_start)
        begin
            vsync_upd = 1'b1;
        end
        if (line_reg == cfg.vsync_stop)
        begin
            vsync_upd = 1'b0;
        end
        is_last    = (line_reg == cfg.last_line);
        info.line  = line_reg;
        info.row   = row_reg;
        info.vsync = vsync_upd;
        info.show  = !is_last && (line_reg < {1'b0, cfg.visible_lines});
    end

    always_comb
    begin
        line_next  = line_reg;
        row_next   = row_reg;
        sub_next   = sub_reg;
        vsync_next = vsync_reg;
        if (tick)
        begin
            vsync_next = vsync_upd;
            if (is_last || (line_reg == LINE_MAX))
            begin
                line_next = '0;
                row_next  = '0;
                sub_next  = '0;
            end
            else
            begin
                line_next = line_reg + LINE_W'(1);
                if (sub_reg == SUB_W'(ROW_HEIGHT - 1))
                begin
                    sub_next = '0;
                    row_next = row_reg + LINE_W'(1);
                end
                else
                begin
                    sub_next = sub_reg + SUB_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= '0;
            row_reg   <= '0;
            sub_reg   <= '0;
            vsync_reg <= 1'b0;
        end
        else
        begin
            line_reg  <= line_next;
            row_reg   <= row_next;
            sub_reg   <= sub_next;
            vsync_reg <= vsync_next;
        end
    end

endmodule

/* rtl/core/tvg_walker.sv */
// Sequencer that sweeps one shared address counter for clearing, fills and line scan-out.
module tvg_walker #(
    parameter int TILE_COLUMNS = 60,
    parameter int TILE_ROWS    = 60,
    parameter int COL_W        = 6,
    parameter int ROW_W        = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                mode,
    input  logic [7:0]          left,
    input  logic [7:0]          top,
    input  logic [7:0]          right,
    input  logic [7:0]          bottom,
    input  logic [7:0]          fill_color,
    input  tvg_pkg::tick_info_t info,
    output logic                tick,
    output logic                busy,
    output logic                result_valid,
    output logic [7:0]          pixel_color,
    output logic                visible,
    output logic                vsync_active,
    output logic [9:0]          line_index,
    output logic                last_of_line
);
    import tvg_pkg::*;

    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = TILE_ROWS * (2 ** COL_W);

    localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(TILE_COLUMNS - 1);
    localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(TILE_ROWS - 1);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_EMIT,
        S_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  x1_reg, x1_next;
    logic [COL_W-1:0]  x2_reg, x2_next;
    logic [ROW_W-1:0]  y2_reg, y2_next;
    logic [7:0]        color_reg, color_next;
    tick_info_t        info_reg, info_next;
    logic              grid_reg, grid_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;

    logic [COL_W-1:0]  fx1, fx2;
    logic [ROW_W-1:0]  fy1, fy2;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        rd_data;

    assign fx1 = (left > 8'(TILE_COLUMNS - 1)) ? LAST_COL : left[COL_W-1:0];
    assign fx2 = (right > 8'(TILE_COLUMNS - 1)) ? LAST_COL : right[COL_W-1:0];
    assign fy1 = (top > 8'(TILE_ROWS - 1)) ? LAST_ROW : top[ROW_W-1:0];
    assign fy2 = (bottom > 8'(TILE_ROWS - 1)) ? LAST_ROW : bottom[ROW_W-1:0];

    assign addr    = {row_reg, col_reg};
    assign wr_en   = (state_reg == S_CLEAR) || (state_reg == S_FILL);
    assign wr_data = (state_reg == S_CLEAR) ? 8'd0 : color_reg;
    assign tick    = start && (state_reg == S_IDLE) && !mode;
    assign busy    = (state_reg != S_IDLE);

    tvg_tile_mem #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (state_reg == S_EMIT),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        color_next     = color_reg;
        info_next      = info_reg;
        grid_next      = grid_reg;
        out_valid_next = 1'b0;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                {row_next, col_next} = addr + ADDR_W'(1);
                if (addr == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode)
                    begin
                        x1_next    = fx1;
                        x2_next    = fx2;
                        y2_next    = fy2;
                        color_next = fill_color & COLOR_MASK;
                        row_next   = fy1;
                        col_next   = fx1;
                        if ((fx1 <= fx2) && (fy1 <= fy2))
                        begin
                            state_next = S_FILL;
                        end
                    end
                    else
                    begin
                        info_next = info;
                        grid_next = (info.row < LINE_W'(TILE_ROWS));
                        row_next  = info.row[ROW_W-1:0];
                        col_next  = '0;
                        if (info.show)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            state_next     = S_DRAIN;
                        end
                    end
                end
            end
            S_FILL:
            begin
                if (col_reg == x2_reg)
                begin
                    col_next = x1_reg;
                    if (row_reg == y2_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            S_EMIT:
            begin
                out_valid_next = 1'b1;
                out_last_next  = (col_reg == LAST_COL);
                if (col_reg == LAST_COL)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y2_reg        <= '0;
            color_reg     <= '0;
            info_reg      <= '0;
            grid_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            x1_reg        <= x1_next;
            x2_reg        <= x2_next;
            y2_reg        <= y2_next;
            color_reg     <= color_next;
            info_reg      <= info_next;
            grid_reg      <= grid_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign pixel_color  = (info_reg.show && grid_reg) ? rd_data : 8'd0;
    assign visible      = info_reg.show;
    assign vsync_active = info_reg.vsync;
    assign line_index   = info_reg.line;
    assign last_of_line = out_last_reg;

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> busy)
        else $error("Result strobe seen while the block is idle.");

    a_no_write_during_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !out_valid_reg)
        else $error("Store write overlaps a result.");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |=> !out_valid_reg)
        else $error("A result follows the end of a line without a new request.");

    a_emit_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (col_reg <= LAST_COL))
        else $error("Scan-out column ran past the grid.");

endmodule

/* verif/tile_scan_checker.sv */
// Checker for the tile scan-out block: predicts every result from observed requests and compares.
module tile_scan_checker
    import tvg_pkg::*;
#(
    parameter int TILE_COLUMNS = 60,
    parameter int TILE_ROWS    = 60,
    parameter int ROW_HEIGHT   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  mode,
    input  logic [COORD_W-1:0]    left,
    input  logic [COORD_W-1:0]    top,
    input  logic [COORD_W-1:0]    right,
    input  logic [COORD_W-1:0]    bottom,
    input  logic [COLOR_W-1:0]    fill_color,
    input  logic                  result_valid,
    input  logic [COLOR_W-1:0]    pixel_color,
    input  logic                  visible,
    input  logic                  vsync_active,
    input  logic [LINE_W-1:0]     line_index,
    input  logic                  last_of_line,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_FILL = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               shown;
        logic               vsync;
        logic [LINE_W-1:0]  line;
        logic               last;
    } scan_px_t;

    logic [COLOR_W-1:0] tiles [TILE_COLUMNS*TILE_ROWS];
    cfg_t               frame;
    logic [LINE_W-1:0]  line_cnt;
    logic               vsync_state;
    scan_px_t           due_pixels [$];

    function automatic int clamp_tile(input logic [COORD_W-1:0] v, input int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic void paint_rect(input logic [COORD_W-1:0] x1r, y1r, x2r, y2r,
                                       input logic [COLOR_W-1:0] c);
        int x1;
        int y1;
        int x2;
        int y2;
        x1 = clamp_tile(x1r, TILE_COLUMNS - 1);
        y1 = clamp_tile(y1r, TILE_ROWS - 1);
        x2 = clamp_tile(x2r, TILE_COLUMNS - 1);
        y2 = clamp_tile(y2r, TILE_ROWS - 1);
        for (int y = y1; y <= y2; y++)
        begin
            for (int x = x1; x <= x2; x++)
            begin
                tiles[y*TILE_COLUMNS + x] = c & COLOR_MASK;
            end
        end
    endfunction

    function automatic void scan_line();
        logic [LINE_W-1:0] ln;
        int                row;
        scan_px_t          px;
        ln = line_cnt;
        if (ln == frame.vsync_start)
        begin
            vsync_state = 1'b1;
        end
        if (ln == frame.vsync_stop)
        begin
            vsync_state = 1'b0;
        end
        px.color = '0;
        px.shown = 1'b0;
        px.vsync = vsync_state;
        px.line  = ln;
        px.last  = 1'b1;
        if (ln == frame.last_line)
        begin
            line_cnt = '0;
            due_pixels.push_back(px);
        end
        else
        begin
            line_cnt = ln + LINE_W'(1);
            if (ln < {1'b0, frame.visible_lines})
            begin
                row = int'(ln) / ROW_HEIGHT;
                px.shown = 1'b1;
                for (int k = 0; k < TILE_COLUMNS; k++)
                begin
                    px.color = (row < TILE_ROWS) ? tiles[row*TILE_COLUMNS + k] : '0;
                    px.last  = (k == TILE_COLUMNS - 1);
                    due_pixels.push_back(px);
                end
            end
            else
            begin
                due_pixels.push_back(px);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scan_px_t want;
        int       bad;
        if (!rst_n)
        begin
            foreach (tiles[i])
            begin
                tiles[i] = '0;
            end
            frame      = '{RST_LAST_LINE, RST_VSYNC_START, RST_VSYNC_STOP, RST_VISIBLE_LINES};
            line_cnt   = '0;
            vsync_state = 1'b0;
            due_pixels.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            bad = 0;
            if (result_valid)
            begin
                if (due_pixels.size() == 0)
                begin
                    $error("unexpected result: line_index %0d, pixel_color %0d",
                           line_index, pixel_color);
                    bad++;
                end
                else
                begin
                    want = due_pixels.pop_front();
                    if (pixel_color !== want.color)
                    begin
                        $error("pixel_color: expected %0d, got %0d", want.color, pixel_color);
                        bad++;
                    end
                    if (visible !== want.shown)
                    begin
                        $error("visible: expected %0d, got %0d", want.shown, visible);
                        bad++;
                    end
                    if (vsync_active !== want.vsync)
                    begin
                        $error("vsync_active: expected %0d, got %0d", want.vsync, vsync_active);
                        bad++;
                    end
                    if (line_index !== want.line)
                    begin
                        $error("line_index: expected %0d, got %0d", want.line, line_index);
                        bad++;
                    end
                    if (last_of_line !== want.last)
                    begin
                        $error("last_of_line: expected %0d, got %0d", want.last, last_of_line);
                        bad++;
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LAST_LINE:     frame.last_line     = cfg_data;
                    REG_VSYNC_START:   frame.vsync_start   = cfg_data;
                    REG_VSYNC_STOP:    frame.vsync_stop    = cfg_data;
                    REG_VISIBLE_LINES: frame.visible_lines = cfg_data[VIS_W-1:0];
                    default:           ;
                endcase
            end
            if (start && !busy)
            begin
                if (mode == MODE_FILL)
                begin
                    paint_rect(left, top, right, bottom, fill_color);
                end
                else
                begin
                    scan_line();
                end
            end
            fail_count <= fail_count + bad;
            pending    <= due_pixels.size();
        end
    end

endmodule

/* verif/tb.sv */
// Testbench top: drives requests and register writes into the tile scan-out block.
module tb
    import tvg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_FILL = 1'b1;
    localparam int   COLS      = 60;
    localparam int   ROWS      = 60;
    localparam int   LIMIT     = 3_000_000;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic                  mode         = MODE_TICK;
    logic [COORD_W-1:0]    left         = '0;
    logic [COORD_W-1:0]    top          = '0;
    logic [COORD_W-1:0]    right        = '0;
    logic [COORD_W-1:0]    bottom       = '0;
    logic [COLOR_W-1:0]    fill_color   = '0;
    logic                  result_valid;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  visible;
    logic                  vsync_active;
    logic [LINE_W-1:0]     line_index;
    logic                  last_of_line;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_LAST_LINE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    int                    fail_count;
    int                    pending;
    int                    cycles       = 0;
    bit                    idle_on      = 1'b1;

    tile_vga_scanline_generator DUT (.*);

    tile_scan_checker scan_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    task automatic issue(input logic m, input logic [7:0] l, t, r, b, c);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        left       <= l;
        top        <= t;
        right      <= r;
        bottom     <= b;
        fill_color <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic tick();
        issue(MODE_TICK, any_byte(), any_byte(), any_byte(), any_byte(), any_byte());
    endtask

    task automatic random_request();
        int x;
        int y;
        x = $urandom_range(0, COLS - 1);
        y = $urandom_range(0, ROWS - 1);
        if ($urandom_range(0, 1) == 0)
        begin
            tick();
        end
        else if ($urandom_range(0, 9) < 7)
        begin
            issue(MODE_FILL, 8'(x), 8'(y), 8'(x + $urandom_range(0, 7)),
                  8'(y + $urandom_range(0, 7)), any_byte());
        end
        else
        begin
            issue(MODE_FILL, any_byte(), any_byte(), any_byte(), any_byte(), any_byte());
        end
    endtask

    task automatic program_frame(input int last, input int vs_on, input int vs_off,
                                 input int shown);
        cfg_write <= 1'b1;
        cfg_index <= REG_LAST_LINE;
        cfg_data  <= CFG_DATA_W'(last);
        @(posedge clk);
        cfg_index <= REG_VSYNC_START;
        cfg_data  <= CFG_DATA_W'(vs_on);
        @(posedge clk);
        cfg_index <= REG_VSYNC_STOP;
        cfg_data  <= CFG_DATA_W'(vs_off);
        @(posedge clk);
        cfg_index <= REG_VISIBLE_LINES;
        cfg_data  <= CFG_DATA_W'(shown);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int last;
        int vs;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);

        // Clamped fills, empty rectangles and masked colors, then the first lines of the frame.
        issue(MODE_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 8'hFF);
        issue(MODE_FILL, 8'd10, 8'd0, 8'd9, 8'd59, 8'h30);
        issue(MODE_FILL, 8'd0, 8'd10, 8'd59, 8'd9, 8'h30);
        issue(MODE_FILL, 8'd200, 8'd200, 8'd255, 8'd255, 8'hC3);
        issue(MODE_FILL, 8'd0, 8'd0, 8'd29, 8'd0, 8'h30);
        issue(MODE_FILL, 8'd5, 8'd0, 8'd7, 8'd0, 8'hAA);
        issue(MODE_FILL, 8'd0, 8'd1, 8'd59, 8'd1, 8'h55);
        issue(MODE_FILL, 8'd59, 8'd0, 8'd59, 8'd59, 8'h0F);
        repeat (10) tick();
        drain();

        for (int p = 0; p < 4; p++)
        begin
            last = 40 + 20*p + $urandom_range(0, 15);
            vs   = $urandom_range(0, last);
            case (p)
                0:       program_frame(last, 0, vs, $urandom_range(1, last));
                1:       program_frame(last, vs, vs, 0);
                2:       program_frame(last, vs, $urandom_range(0, 1023), 480);
                default: program_frame(last, vs, $urandom_range(0, last),
                                       $urandom_range(0, last));
            endcase
            idle_on = (p < 3);
            repeat (85) random_request();
            drain();
        end

        // A long frame, then a final line below the counter so it counts on past it.
        program_frame(1023, 1023, 0, 0);
        repeat (30) tick();
        drain();
        program_frame(1, 0, 1023, 1);
        repeat (30) tick();
        drain();

        repeat (70) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
